>>> rtl/core/u8u16_pkg.sv
`default_nettype none

package u8u16_pkg;

    localparam int EscSlots  = 4;
    localparam int TailSlots = 2;
    localparam int HeldDepth = 3;

    localparam logic [15:0] EscHigh     = 16'hDBFF;
    localparam logic [15:0] EscLowBase  = 16'hDE00;
    localparam logic [15:0] SurHighBase = 16'hD800;
    localparam logic [15:0] SurLowBase  = 16'hDC00;
    localparam logic [20:0] PlaneOne    = 21'h010000;
    localparam logic [20:0] BmpMax      = 21'h00FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_word;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_end;
        logic        string_end;
    } t_out_word;

    // Everything one input byte emits: escape pairs first, then plain units.
    typedef struct packed {
        logic [EscSlots-1:0][7:0]   esc_bytes;
        logic [TailSlots-1:0][15:0] tail_units;
        logic [2:0]                 esc_cnt;
        logic [3:0]                 unit_cnt;
        logic                       final_byte;
    } t_job;

endpackage

`default_nettype wire

>>> rtl/core/u8u16_front.sv
`default_nettype none

module u8u16_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire u8u16_pkg::t_in_word i_word,
    output      logic               o_push,
    output      u8u16_pkg::t_job    o_job
);
    import u8u16_pkg::*;

    logic [1:0]  r_bytes_needed, n_bytes_needed;
    logic [1:0]  r_seq_len, n_seq_len;
    logic [20:0] r_acc, n_acc;
    logic [7:0]  r_held [HeldDepth];
    logic [7:0]  n_held [HeldDepth];

    logic [7:0]  in_byte;
    logic        fin;
    logic [20:0] acc_shift;
    logic [20:0] cp_off;
    logic [1:0]  flush_cnt;
    logic        flush_new;
    logic        append;
    logic [1:0]  tail_cnt;
    logic [7:0]  src [HeldDepth];

    assign in_byte   = i_word.data_byte;
    assign fin       = i_word.final_byte;
    assign acc_shift = {r_acc[14:0], in_byte[5:0]};
    assign cp_off    = acc_shift - PlaneOne;

    always_comb begin
        n_bytes_needed = r_bytes_needed;
        n_seq_len      = r_seq_len;
        n_acc          = r_acc;
        n_held         = r_held;
        flush_cnt      = 2'd0;
        flush_new      = 1'b0;
        append         = 1'b0;
        tail_cnt       = 2'd0;
        o_job          = '0;

        if (r_bytes_needed != 2'd0 && in_byte[7:6] == 2'b10) begin
            n_acc          = acc_shift;
            n_bytes_needed = r_bytes_needed - 2'd1;
            if (r_bytes_needed == 2'd1) begin
                n_seq_len = 2'd0;
                if (acc_shift > BmpMax) begin
                    o_job.tail_units[0] = SurHighBase + {5'd0, cp_off[20:10]};
                    o_job.tail_units[1] = SurLowBase + {6'd0, cp_off[9:0]};
                    tail_cnt = 2'd2;
                end else begin
                    o_job.tail_units[0] = acc_shift[15:0];
                    tail_cnt = 2'd1;
                end
            end else begin
                if (r_seq_len != 2'd3) begin
                    n_held[r_seq_len] = in_byte;
                    n_seq_len = r_seq_len + 2'd1;
                end
                // unfinished at the last byte: escape everything held
                if (fin) begin
                    flush_cnt = n_seq_len;
                    flush_new = 1'b1;
                end
            end
        end else begin
            if (r_bytes_needed != 2'd0) begin
                flush_cnt = r_seq_len;
            end
            n_bytes_needed = 2'd0;
            n_seq_len      = 2'd0;
            case (in_byte) inside
                [8'h00:8'h7F]: begin
                    o_job.tail_units[0] = {8'd0, in_byte};
                    tail_cnt = 2'd1;
                end
                [8'hC0:8'hDF]: begin
                    n_acc = {16'd0, in_byte[4:0]};
                    n_bytes_needed = 2'd1;
                end
                [8'hE0:8'hEF]: begin
                    n_acc = {17'd0, in_byte[3:0]};
                    n_bytes_needed = 2'd2;
                end
                [8'hF0:8'hF7]: begin
                    n_acc = {18'd0, in_byte[2:0]};
                    n_bytes_needed = 2'd3;
                end
                default: begin
                    append = 1'b1;
                end
            endcase
            if (n_bytes_needed != 2'd0) begin
                n_held[0] = in_byte;
                n_seq_len = 2'd1;
                if (fin) begin
                    append = 1'b1;
                end
            end
        end

        if (fin) begin
            n_bytes_needed = 2'd0;
            n_seq_len      = 2'd0;
        end

        for (int k = 0; k < HeldDepth; k++) begin
            src[k] = flush_new ? n_held[k] : r_held[k];
        end
        for (int k = 0; k < HeldDepth; k++) begin
            o_job.esc_bytes[k] = (2'(k) < flush_cnt) ? src[k] : in_byte;
        end
        o_job.esc_bytes[EscSlots-1] = in_byte;
        o_job.esc_cnt    = {1'b0, flush_cnt} + {2'd0, append};
        o_job.unit_cnt   = {o_job.esc_cnt, 1'b0} + {2'd0, tail_cnt};
        o_job.final_byte = fin;
    end

    assign o_push = i_accept && (o_job.unit_cnt != 4'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_needed <= 2'd0;
            r_seq_len      <= 2'd0;
            r_acc          <= '0;
        end else if (i_accept) begin
            r_bytes_needed <= n_bytes_needed;
            r_seq_len      <= n_seq_len;
            r_acc          <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held <= n_held;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/u8u16_queue.sv
`default_nettype none

module u8u16_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire u8u16_pkg::t_job i_job,
    input  wire logic            i_pop,
    output      logic            o_full,
    output      logic            o_valid,
    output      u8u16_pkg::t_job o_job
);
    import u8u16_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/u8u16_back.sv
`default_nettype none

module u8u16_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_job_valid,
    input  wire u8u16_pkg::t_job     i_job,
    output      logic                o_pop,
    output      logic                o_out_valid,
    input  wire logic                i_out_stall,
    output      u8u16_pkg::t_out_word o_out_data
);
    import u8u16_pkg::*;

    logic [2:0]  r_idx, n_idx;
    logic        r_out_valid;
    t_out_word   r_out;

    logic        load;
    logic        last;
    logic [3:0]  esc_units;
    logic [7:0]  esc_byte;
    logic [15:0] unit;

    assign load      = i_job_valid && (!r_out_valid || !i_out_stall);
    assign esc_units = {i_job.esc_cnt, 1'b0};
    assign esc_byte  = i_job.esc_bytes[r_idx[2:1]];
    assign last      = ({1'b0, r_idx} == (i_job.unit_cnt - 4'd1));
    assign o_pop     = load && last;

    always_comb begin
        if ({1'b0, r_idx} < esc_units) begin
            unit = r_idx[0] ? (EscLowBase + {8'd0, esc_byte}) : EscHigh;
        end else begin
            // escape units come in pairs, so the tail slot is the low index bit
            unit = i_job.tail_units[r_idx[0]];
        end
        n_idx = r_idx;
        if (load) begin
            n_idx = last ? 3'd0 : r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.code_unit  <= unit;
            r_out.run_end    <= last;
            r_out.string_end <= last && i_job.final_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> rtl/core/utf8_to_utf16_decoder_unit.sv
`default_nettype none

// UTF-8 to UTF-16 decoder. One byte is taken per cycle whenever the two-entry
// job queue has room; the front end updates the sequence state in that same
// cycle and queues the units the byte produces. Unless the output stalls, the
// back end sends one code unit per cycle from the queue head into a registered
// output; a byte yielding n units (up to eight for a broken sequence followed
// by a bad byte) holds it until all n are sent, and ASCII or completing bytes
// that yield one unit each run at one byte per cycle. Continuation and lead
// bytes that only extend a sequence produce nothing and cost no back-end time.
// A byte's first unit goes through the job queue, then the output register.
module utf8_to_utf16_decoder_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output      logic                 o_in_stall,
    input  wire u8u16_pkg::t_in_word  i_in_data,
    output      logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    output      u8u16_pkg::t_out_word o_out_data
);
    import u8u16_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic full;
    logic head_valid;
    t_job new_job;
    t_job head_job;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    u8u16_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_word   (i_in_data),
        .o_push   (push),
        .o_job    (new_job)
    );

    u8u16_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (new_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    u8u16_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (head_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
